FILE: rtl/dod_pkg.sv
// dod_pkg: shared types and constants of the detection output decoder
// no dependencies; used by every dod_* module and by detection_output_decoder
`default_nettype none

package dod_pkg;

  // channel layout of one prediction
  localparam logic [6:0] CH_CX     = 7'd0;
  localparam logic [6:0] CH_OBJ    = 7'd4;
  localparam logic [6:0] CH_CLASS0 = 7'd5;

  localparam int unsigned MIN_CHANNELS = 6;
  localparam int unsigned MAX_CHANNELS = 128;

  // classes that are passed on
  localparam logic [6:0] CLASS_KEEP_A = 7'd0;
  localparam logic [6:0] CLASS_KEEP_B = 7'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_CONF_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_FRAME_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_FRAME_HEIGHT   = 2'd2;
  localparam logic [1:0] CFG_NUM_CHANNELS   = 2'd3;

  localparam logic [15:0] RST_CONF_THRESHOLD = 16'd26214;
  localparam logic [12:0] RST_FRAME_WIDTH    = 13'd640;
  localparam logic [12:0] RST_FRAME_HEIGHT   = 13'd640;
  localparam logic [7:0]  RST_NUM_CHANNELS   = 8'd85;

  // output queue
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_PTR_W = 3;
  localparam int unsigned OUT_CNT_W = 4;

  // edge = (2*c - s) * scale / 2^17, truncated toward zero
  localparam logic signed [31:0] EDGE_BIAS = 32'sd131071;

  typedef struct packed {
    logic        pass;
    logic        seen;
    logic [6:0]  cls;
    logic [15:0] best;
  } score_t;

  typedef struct packed {
    logic        hit;
    logic [12:0] box_index;
    logic [6:0]  class_id;
  } dec_t;

  typedef struct packed {
    logic               [12:0] box_index;
    logic               [6:0]  class_id;
    logic signed        [13:0] left;
    logic signed        [13:0] top;
    logic               [12:0] box_width;
    logic               [12:0] box_height;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/dod_box_store.sv
// dod_box_store: box memory, four 16-bit lanes (cx, cy, w, h) per prediction
// uses dod_pkg; lane writes at accept, registered synchronous read
`default_nettype none

module dod_box_store #(
  parameter int unsigned Depth = 8192,
  parameter int unsigned AddrW = 13
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [1:0]       lane_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [15:0]      wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [63:0]      rdata_o
);
  import dod_pkg::*;

  logic [63:0] mem [Depth];
  logic [3:0]  lane_en;
  logic        first_lane;
  logic [63:0] rdata_q;

  // the cx beat starts a new prediction and zeroes the other lanes
  assign first_lane = (lane_i == CH_CX[1:0]);

  always_comb begin
    lane_en = 4'b0000;
    if (first_lane) begin
      lane_en = 4'b1111;
    end else begin
      lane_en[lane_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int l = 0; l < 4; l++) begin
        if (lane_en[l]) begin
          mem[waddr_i][l*16 +: 16] <= (first_lane && l != 0) ? 16'd0 : wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/dod_score_unit.sv
// dod_score_unit: score memory with read-modify-write, write forwarding and
// the per-prediction decision on the last channel; uses dod_pkg
`default_nettype none

module dod_score_unit #(
  parameter int unsigned Depth = 8192,
  parameter int unsigned AddrW = 13
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                acc_i,
  input  wire logic [15:0]         value_i,
  input  wire logic [6:0]          channel_i,
  input  wire logic [12:0]         prediction_i,
  input  wire logic [AddrW-1:0]    addr_i,
  input  wire logic [15:0]         conf_threshold_i,
  input  wire logic [7:0]          num_channels_i,
  output logic                     busy_o,
  output dod_pkg::dec_t            dec_o
);
  import dod_pkg::*;

  score_t           mem [Depth];
  score_t           rdata_q;

  logic             vld_q;
  logic [15:0]      val_q;
  logic [6:0]       ch_q;
  logic [12:0]      pred_q;
  logic [AddrW-1:0] addr_q;

  logic             fwd_vld_q;
  logic [AddrW-1:0] fwd_addr_q;
  score_t           fwd_data_q;

  score_t           cur;
  score_t           nxt;
  score_t           wdata;
  logic             we;
  logic             chans_ok;
  logic             is_cls;
  logic             upd;
  logic             is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      vld_q     <= acc_i;
      fwd_vld_q <= we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      val_q   <= value_i;
      ch_q    <= channel_i;
      pred_q  <= prediction_i;
      addr_q  <= addr_i;
      rdata_q <= mem[addr_i];
    end
    if (we) begin
      mem[addr_q] <= wdata;
      fwd_addr_q  <= addr_q;
      fwd_data_q  <= wdata;
    end
  end

  // the read issued at the edge of the previous write missed that write
  assign cur = (fwd_vld_q && fwd_addr_q == addr_q) ? fwd_data_q : rdata_q;

  assign chans_ok = (num_channels_i >= 8'(MIN_CHANNELS)) &&
                    ({1'b0, num_channels_i} <= 9'(MAX_CHANNELS));
  assign is_cls   = chans_ok && (ch_q >= CH_CLASS0) && ({1'b0, ch_q} < num_channels_i);
  assign upd      = is_cls && (val_q > cur.best);
  assign is_last  = is_cls && ({1'b0, ch_q} == (num_channels_i - 8'd1));

  always_comb begin
    nxt = cur;
    if (upd) begin
      nxt.seen = 1'b1;
      nxt.cls  = ch_q - CH_CLASS0;
      nxt.best = val_q;
    end
  end

  always_comb begin
    wdata = nxt;
    we    = 1'b0;
    if (vld_q) begin
      if (ch_q == CH_CX) begin
        wdata = '0;
        we    = 1'b1;
      end else if (ch_q == CH_OBJ) begin
        wdata      = cur;
        wdata.pass = (val_q >= conf_threshold_i);
        we         = 1'b1;
      end else begin
        we = upd;
      end
    end
  end

  always_comb begin
    dec_o.hit = vld_q && is_last && nxt.pass && nxt.seen &&
                (nxt.best >= conf_threshold_i) &&
                (nxt.cls == CLASS_KEEP_A || nxt.cls == CLASS_KEEP_B);
    dec_o.box_index = pred_q;
    dec_o.class_id  = nxt.cls;
  end

  assign busy_o = vld_q;

`ifndef SYNTHESIS
  // a hit always has a seen class, set by this update or an earlier one
  a_hit_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_o.hit |-> (nxt.seen && (upd || cur.seen)))
    else $error("decision without a seen class");
  // forwarded data is only ever taken right after a write
  a_fwd_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_vld_q |-> $past(vld_q))
    else $error("forward register valid without a preceding write");
`endif

endmodule

`default_nettype wire

FILE: rtl/dod_scale.sv
// dod_scale: two-stage pixel scaling of an accepted box (operands, products)
// and truncation toward zero; uses dod_pkg
`default_nettype none

module dod_scale (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dod_pkg::dec_t dec_i,
  input  wire logic [63:0]   box_i,
  input  wire logic [12:0]   frame_width_i,
  input  wire logic [12:0]   frame_height_i,
  output logic [1:0]         inflight_o,
  output logic               push_o,
  output dod_pkg::res_t      res_o
);
  import dod_pkg::*;

  logic               v2_q;
  logic [12:0]        idx2_q;
  logic [6:0]         cls2_q;
  logic signed [17:0] dx_q;
  logic signed [17:0] dy_q;
  logic [15:0]        w_q;
  logic [15:0]        h_q;

  logic               v3_q;
  logic [12:0]        idx3_q;
  logic [6:0]         cls3_q;
  logic signed [31:0] px_q;
  logic signed [31:0] py_q;
  logic [28:0]        pw_q;
  logic [28:0]        ph_q;

  logic signed [17:0] dx_d;
  logic signed [17:0] dy_d;
  logic signed [31:0] px_d;
  logic signed [31:0] py_d;
  logic [28:0]        pw_d;
  logic [28:0]        ph_d;
  logic signed [31:0] lx_adj;
  logic signed [31:0] ty_adj;

  // 2*centre - size
  assign dx_d = $signed({1'b0, box_i[15:0], 1'b0}) - $signed({2'b00, box_i[47:32]});
  assign dy_d = $signed({1'b0, box_i[31:16], 1'b0}) - $signed({2'b00, box_i[63:48]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= dec_i.hit;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_i.hit) begin
      idx2_q <= dec_i.box_index;
      cls2_q <= dec_i.class_id;
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      w_q    <= box_i[47:32];
      h_q    <= box_i[63:48];
    end
    if (v2_q) begin
      idx3_q <= idx2_q;
      cls3_q <= cls2_q;
      px_q   <= px_d;
      py_q   <= py_d;
      pw_q   <= pw_d;
      ph_q   <= ph_d;
    end
  end

  assign px_d = 32'(dx_q) * 32'($signed({1'b0, frame_width_i}));
  assign py_d = 32'(dy_q) * 32'($signed({1'b0, frame_height_i}));
  assign pw_d = 29'(w_q) * 29'(frame_width_i);
  assign ph_d = 29'(h_q) * 29'(frame_height_i);

  // negative products get a bias so the arithmetic shift truncates toward zero
  assign lx_adj = px_q + (px_q[31] ? EDGE_BIAS : 32'sd0);
  assign ty_adj = py_q + (py_q[31] ? EDGE_BIAS : 32'sd0);

  always_comb begin
    res_o.box_index  = idx3_q;
    res_o.class_id   = cls3_q;
    res_o.left       = lx_adj[30:17];
    res_o.top        = ty_adj[30:17];
    res_o.box_width  = pw_q[28:16];
    res_o.box_height = ph_q[28:16];
  end

  assign push_o     = v3_q;
  assign inflight_o = {1'b0, v2_q} + {1'b0, v3_q};

endmodule

`default_nettype wire

FILE: rtl/dod_out_fifo.sv
// dod_out_fifo: result queue between the scaling pipeline and the output channel
// uses dod_pkg for the result type and the queue depth
`default_nettype none

module dod_out_fifo (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire dod_pkg::res_t               res_i,
  input  wire logic                        pop_i,
  output logic                             valid_o,
  output dod_pkg::res_t                    res_o,
  output logic [dod_pkg::OUT_CNT_W-1:0]    count_o
);
  import dod_pkg::*;

  res_t                 entry_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q;
  logic [OUT_PTR_W-1:0] rd_ptr_q;
  logic [OUT_CNT_W-1:0] cnt_q;
  logic                 pop;

  assign pop = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + OUT_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - OUT_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= res_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign res_o   = entry_q[rd_ptr_q];
  assign count_o = cnt_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |-> (cnt_q < OUT_CNT_W'(OUT_DEPTH)))
    else $error("result queue overflow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == OUT_CNT_W'(OUT_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

FILE: rtl/detection_output_decoder.sv
// detection_output_decoder: top level, configuration registers, stall control
// depends on dod_pkg, dod_box_store, dod_score_unit, dod_scale, dod_out_fifo
//
// Usage
// - input channel: one tensor element per beat (value_i, channel_i, prediction_i),
//   taken at an edge with in_valid_i high and in_stall_o low; elements of a
//   prediction must start with channel 0, the last channel triggers a decision
// - config channel: cfg_index_i selects threshold, frame width, frame height or
//   channel count; always ready, write only while no beat is in flight
// - output channel: one detection per beat, taken when out_valid_o is high and
//   out_stall_i is low; results leave in the order their last beats arrived
// - throughput: one beat per cycle while in_stall_o is low, set by the one
//   read-modify-write of the score memory per cycle (forwarding covers back-to-back
//   beats on one entry); results pass the score, operand and product registers
// - stall: results wait in an 8-entry queue; in_stall_o rises once the queue
//   plus the beats still in the pipeline could fill it
// - reset: configuration returns to its defaults and the pipeline and queue
//   empty; the box and score memories are not cleared, so every prediction
//   must begin with its channel 0 beat
`default_nettype none

module detection_output_decoder #(
  parameter int unsigned MAX_PREDICTIONS = 8192
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] value_i,
  input  wire logic [6:0]  channel_i,
  input  wire logic [12:0] prediction_i,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [12:0]      box_index_o,
  output logic [6:0]       class_id_o,
  output logic signed [13:0] left_o,
  output logic signed [13:0] top_o,
  output logic [12:0]      box_width_o,
  output logic [12:0]      box_height_o
);
  import dod_pkg::*;

  localparam int unsigned AddrW = (MAX_PREDICTIONS > 1) ? $clog2(MAX_PREDICTIONS) : 1;

  logic [15:0]          conf_threshold_q;
  logic [12:0]          frame_width_q;
  logic [12:0]          frame_height_q;
  logic [7:0]           num_channels_q;

  logic                 in_acc;
  logic                 in_range;
  logic                 acc;
  logic [16:0]          pred_ext;
  logic [AddrW-1:0]     addr;
  logic                 box_we;

  logic [63:0]          box_rdata;
  logic                 s1_busy;
  dec_t                 dec;
  logic [1:0]           inflight;
  logic                 push;
  res_t                 res;
  res_t                 head;
  logic [OUT_CNT_W-1:0] q_cnt;
  logic [OUT_CNT_W:0]   occupancy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_threshold_q <= RST_CONF_THRESHOLD;
      frame_width_q    <= RST_FRAME_WIDTH;
      frame_height_q   <= RST_FRAME_HEIGHT;
      num_channels_q   <= RST_NUM_CHANNELS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CONF_THRESHOLD: conf_threshold_q <= cfg_data_i;
        CFG_FRAME_WIDTH:    frame_width_q    <= cfg_data_i[12:0];
        CFG_FRAME_HEIGHT:   frame_height_q   <= cfg_data_i[12:0];
        CFG_NUM_CHANNELS:   num_channels_q   <= cfg_data_i[7:0];
        default:            ;
      endcase
    end
  end

  assign pred_ext = 17'(prediction_i);
  assign in_range = (pred_ext < 17'(MAX_PREDICTIONS));
  assign addr     = pred_ext[AddrW-1:0];
  assign in_acc   = in_valid_i && !in_stall_o;
  assign acc      = in_acc && in_range;
  assign box_we   = acc && (channel_i < CH_OBJ);

  // every beat in flight may still end up in the queue
  assign occupancy  = {1'b0, q_cnt} + (OUT_CNT_W+1)'(s1_busy) + (OUT_CNT_W+1)'(inflight);
  assign in_stall_o = (occupancy >= (OUT_CNT_W+1)'(OUT_DEPTH));

  dod_box_store #(
    .Depth (MAX_PREDICTIONS),
    .AddrW (AddrW)
  ) u_box (
    .clk_i   (clk_i),
    .we_i    (box_we),
    .lane_i  (channel_i[1:0]),
    .waddr_i (addr),
    .wdata_i (value_i),
    .re_i    (acc),
    .raddr_i (addr),
    .rdata_o (box_rdata)
  );

  dod_score_unit #(
    .Depth (MAX_PREDICTIONS),
    .AddrW (AddrW)
  ) u_score (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .acc_i            (acc),
    .value_i          (value_i),
    .channel_i        (channel_i),
    .prediction_i     (prediction_i),
    .addr_i           (addr),
    .conf_threshold_i (conf_threshold_q),
    .num_channels_i   (num_channels_q),
    .busy_o           (s1_busy),
    .dec_o            (dec)
  );

  dod_scale u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dec_i          (dec),
    .box_i          (box_rdata),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .inflight_o     (inflight),
    .push_o         (push),
    .res_o          (res)
  );

  dod_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .pop_i   (!out_stall_i),
    .valid_o (out_valid_o),
    .res_o   (head),
    .count_o (q_cnt)
  );

  assign box_index_o  = head.box_index;
  assign class_id_o   = head.class_id;
  assign left_o       = head.left;
  assign top_o        = head.top;
  assign box_width_o  = head.box_width;
  assign box_height_o = head.box_height;

`ifndef SYNTHESIS
  a_push_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> $past(in_acc, 3))
    else $error("result without an accepted beat three cycles before");
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_cnt == '0 && !s1_busy && inflight == 2'd0) |-> !in_stall_o)
    else $error("input stalled while the block is empty");
`endif

endmodule

`default_nettype wire
